// ===== src/utf8_codepoint_offset_indexer_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 offset indexer assertion macros
// Shared property forms for the indexer checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODEPOINT_OFFSET_INDEXER_DEFINES_SVH
`define UTF8_CODEPOINT_OFFSET_INDEXER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define UCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/uci_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 offset indexer package
// Widths, lead-byte masks, result entry type and the saturating adder.
// ----------------------------------------------------------------------------
`default_nettype none

package uci_pkg;

   localparam int unsigned OFFSET_W    = 16;
   localparam int unsigned VALUE_W     = 21;
   localparam int unsigned MAX_RESULTS = 5;
   localparam int unsigned COUNT_W     = 3;

   localparam logic [31:0] DEFAULT_MAX_TEXT_BYTES = 32'd65535;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [OFFSET_W-1:0] unit_offset;
      logic [VALUE_W-1:0]  scalar_value;
      logic                malformed;
      logic                is_sentinel;
   } entry_type;

   function automatic logic [OFFSET_W-1:0] sat_add(input logic [OFFSET_W-1:0] a,
                                                   input logic [COUNT_W-1:0]  d,
                                                   input logic [OFFSET_W-1:0] lim);
      logic [OFFSET_W:0] sum;
      sum = {1'b0, a} + (OFFSET_W+1)'(d);
      return (sum > {1'b0, lim}) ? lim : sum[OFFSET_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/uci_channels_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 offset indexer channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface uci_req_if import uci_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface uci_rsp_if import uci_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] byte_offset;
   logic [OFFSET_W-1:0] unit_offset;
   logic [VALUE_W-1:0]  scalar_value;
   logic                malformed;
   logic                is_sentinel;
   logic                last_of_run;

   modport source (output valid, output byte_offset, output unit_offset,
                   output scalar_value, output malformed, output is_sentinel,
                   output last_of_run, input ready);
   modport sink   (input valid, input byte_offset, input unit_offset,
                   input scalar_value, input malformed, input is_sentinel,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/utf8_codepoint_offset_indexer.sv =====
// ----------------------------------------------------------------------------
// UTF-8 code point offset indexer
// Decodes a UTF-8 byte stream and reports byte and UTF-16 offsets per scalar.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_bus   in         data_byte, end_of_text
//  rsp_bus   out        byte_offset, unit_offset, scalar_value, malformed,
//                       is_sentinel, last_of_run
//
// One byte per cycle when each byte yields at most one result and rsp ready
// is high; a byte with n results holds req ready low until its last result
// is taken, the buffer draining one entry per cycle while rsp ready is high.
// First result appears the cycle after the byte is taken. Synchronous reset
// clears decoder counts, offsets and result count. A stalled result holds
// its value; the next byte is taken in the cycle the last result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_offset_indexer import uci_pkg::*; #(
   parameter logic [31:0] MAX_TEXT_BYTES = DEFAULT_MAX_TEXT_BYTES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   uci_req_if.sink    req_bus,
   uci_rsp_if.source  rsp_bus
);

   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
      (MAX_TEXT_BYTES < 32'd65535) ? MAX_TEXT_BYTES[OFFSET_W-1:0] : {OFFSET_W{1'b1}};

   // decoder state
   logic [7:0]          pend0_ff, pend1_ff, pend2_ff;
   logic [7:0]          pend0_in, pend1_in, pend2_in;
   logic [1:0]          pcount_ff, pcount_in;
   logic [2:0]          elen_ff, elen_in;
   logic [OFFSET_W-1:0] bc_ff, bc_in, uc_ff, uc_in;

   // result buffer
   entry_type           ent_ff [MAX_RESULTS];
   entry_type           ent_in [MAX_RESULTS];
   logic [COUNT_W-1:0]  n_ff, n_in, idx_ff, idx_in;

   logic       accept, rsp_take, last_show;
   logic [7:0] b;
   logic       last, cont, pend_act, do_lead;
   logic [2:0] lead_len;
   logic [1:0] flush_cnt;
   logic       fin_vld, fin_bad;
   logic [VALUE_W-1:0] fin_val;
   logic [2:0] fin_len;
   logic [OFFSET_W-1:0] bc_a, uc_a, bc_b, uc_b;
   logic [OFFSET_W-1:0] flush_bo [MAX_RESULTS];
   logic [OFFSET_W-1:0] flush_uo [MAX_RESULTS];
   logic [COUNT_W-1:0]  n_new;

   assign b    = req_bus.data_byte;
   assign last = req_bus.end_of_text;
   assign cont = (b & CONT_MASK) == CONT_CODE;
   assign pend_act = (pcount_ff != 2'd0) && (elen_ff >= 3'd2) && (elen_ff <= 3'd4);

   always_comb begin
      if (!b[7])                             lead_len = 3'd1;
      else if ((b & LEAD2_MASK) == LEAD2_CODE) lead_len = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE) lead_len = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE) lead_len = 3'd4;
      else                                   lead_len = 3'd0;
   end

   always_comb begin
      pend0_in  = pend0_ff;
      pend1_in  = pend1_ff;
      pend2_in  = pend2_ff;
      pcount_in = pcount_ff;
      elen_in   = elen_ff;
      flush_cnt = 2'd0;
      fin_vld   = 1'b0;
      fin_bad   = 1'b0;
      fin_val   = '0;
      fin_len   = 3'd1;
      do_lead   = 1'b0;
      if (pend_act) begin
         if (cont) begin
            if (({1'b0, pcount_ff} + 3'd1) == elen_ff) begin
               fin_vld   = 1'b1;
               fin_len   = elen_ff;
               pcount_in = 2'd0;
               elen_in   = 3'd0;
               case (elen_ff)
                  3'd2:    fin_val = VALUE_W'({pend0_ff[4:0], b[5:0]});
                  3'd3:    fin_val = VALUE_W'({pend0_ff[3:0], pend1_ff[5:0], b[5:0]});
                  default: fin_val = {pend0_ff[2:0], pend1_ff[5:0], pend2_ff[5:0], b[5:0]};
               endcase
            end else if (last) begin
               // truncated at end: flush held bytes, then the end byte
               flush_cnt = pcount_ff;
               fin_vld   = 1'b1;
               fin_bad   = 1'b1;
            end else begin
               case (pcount_ff)
                  2'd1:    pend1_in = b;
                  2'd2:    pend2_in = b;
                  default: ;
               endcase
               pcount_in = pcount_ff + 2'd1;
            end
         end else begin
            // broken sequence: flush, then treat this byte as a lead
            flush_cnt = pcount_ff;
            pcount_in = 2'd0;
            elen_in   = 3'd0;
            do_lead   = 1'b1;
         end
      end else begin
         pcount_in = 2'd0;
         elen_in   = 3'd0;
         do_lead   = 1'b1;
      end
      if (do_lead) begin
         if (!b[7]) begin
            fin_vld = 1'b1;
            fin_val = VALUE_W'(b);
         end else if (lead_len == 3'd0 || last) begin
            fin_vld = 1'b1;
            fin_bad = 1'b1;
         end else begin
            pend0_in  = b;
            pcount_in = 2'd1;
            elen_in   = lead_len;
         end
      end
      if (last) begin
         pcount_in = 2'd0;
         elen_in   = 3'd0;
      end
   end

   // offsets
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         flush_bo[i] = sat_add(bc_ff, COUNT_W'(i), OFFSET_LIMIT);
         flush_uo[i] = sat_add(uc_ff, COUNT_W'(i), OFFSET_LIMIT);
      end
   end

   assign bc_a = sat_add(bc_ff, {1'b0, flush_cnt}, OFFSET_LIMIT);
   assign uc_a = sat_add(uc_ff, {1'b0, flush_cnt}, OFFSET_LIMIT);
   assign bc_b = fin_vld ? sat_add(bc_a, fin_len, OFFSET_LIMIT) : bc_a;
   assign uc_b = fin_vld ? sat_add(uc_a, (|fin_val[VALUE_W-1:16]) ? 3'd2 : 3'd1,
                                   OFFSET_LIMIT) : uc_a;

   assign bc_in = last ? '0 : bc_b;
   assign uc_in = last ? '0 : uc_b;

   // pack the entries of this byte: flushed bytes, final entry, sentinel
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (COUNT_W'(i) < {1'b0, flush_cnt}) begin
            ent_in[i] = '{byte_offset: flush_bo[i], unit_offset: flush_uo[i],
                          scalar_value: '0, malformed: 1'b1, is_sentinel: 1'b0};
         end else if (COUNT_W'(i) == {1'b0, flush_cnt} && fin_vld) begin
            ent_in[i] = '{byte_offset: bc_a, unit_offset: uc_a,
                          scalar_value: fin_val, malformed: fin_bad, is_sentinel: 1'b0};
         end else begin
            ent_in[i] = '{byte_offset: bc_b, unit_offset: uc_b,
                          scalar_value: '0, malformed: 1'b0, is_sentinel: 1'b1};
         end
      end
   end

   assign n_new = {1'b0, flush_cnt} + COUNT_W'(fin_vld) + COUNT_W'(last);

   // handshake
   assign rsp_take        = rsp_bus.valid && rsp_bus.ready;
   assign last_show       = idx_ff == (n_ff - COUNT_W'(1));
   assign req_bus.ready   = (n_ff == '0) || (rsp_take && last_show);
   assign accept          = req_bus.valid && req_bus.ready;

   always_comb begin
      n_in   = n_ff;
      idx_in = idx_ff;
      if (accept) begin
         n_in   = n_new;
         idx_in = '0;
      end else if (rsp_take) begin
         if (last_show) begin
            n_in   = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         elen_ff   <= '0;
         bc_ff     <= '0;
         uc_ff     <= '0;
         n_ff      <= '0;
         idx_ff    <= '0;
      end else begin
         n_ff   <= n_in;
         idx_ff <= idx_in;
         if (accept) begin
            pcount_ff <= pcount_in;
            elen_ff   <= elen_in;
            bc_ff     <= bc_in;
            uc_ff     <= uc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
         pend2_ff <= pend2_in;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            ent_ff[i] <= ent_in[i];
         end
      end
   end

   assign rsp_bus.valid        = n_ff != '0;
   assign rsp_bus.byte_offset  = ent_ff[idx_ff].byte_offset;
   assign rsp_bus.unit_offset  = ent_ff[idx_ff].unit_offset;
   assign rsp_bus.scalar_value = ent_ff[idx_ff].scalar_value;
   assign rsp_bus.malformed    = ent_ff[idx_ff].malformed;
   assign rsp_bus.is_sentinel  = ent_ff[idx_ff].is_sentinel;
   assign rsp_bus.last_of_run  = last_show;

endmodule

`default_nettype wire

// ===== src/uci_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 offset indexer checker
// Port-level properties of the indexer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_codepoint_offset_indexer_defines.svh"

module uci_checker import uci_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [OFFSET_W-1:0] rsp_byte_offset,
   input wire logic [OFFSET_W-1:0] rsp_unit_offset,
   input wire logic [VALUE_W-1:0]  rsp_scalar_value,
   input wire logic                rsp_malformed,
   input wire logic                rsp_is_sentinel,
   input wire logic                rsp_last_of_run
);

   `UCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_byte_offset) && $stable(rsp_unit_offset)
         && $stable(rsp_scalar_value) && $stable(rsp_malformed)
         && $stable(rsp_is_sentinel) && $stable(rsp_last_of_run),
      "stalled result changed")
   `UCI_ASSERT_NOW(a_sentinel_shape, clock, reset, rsp_valid && rsp_is_sentinel,
      rsp_last_of_run && !rsp_malformed && rsp_scalar_value == '0,
      "sentinel is not a clean final entry")
   `UCI_ASSERT_NOW(a_malformed_zero, clock, reset, rsp_valid && rsp_malformed,
      rsp_scalar_value == '0 && !rsp_is_sentinel,
      "malformed entry carries a value")
   `UCI_ASSERT_NOW(a_burst_blocks_input, clock, reset, rsp_valid && !rsp_last_of_run,
      !req_ready,
      "byte taken while a result run is still draining")

endmodule

bind utf8_codepoint_offset_indexer uci_checker u_uci_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_byte_offset  (rsp_bus.byte_offset),
   .rsp_unit_offset  (rsp_bus.unit_offset),
   .rsp_scalar_value (rsp_bus.scalar_value),
   .rsp_malformed    (rsp_bus.malformed),
   .rsp_is_sentinel  (rsp_bus.is_sentinel),
   .rsp_last_of_run  (rsp_bus.last_of_run)
);

`default_nettype wire

// ===== tb/tb_utf8_codepoint_offset_indexer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 code point offset indexer testbench
// Streams UTF-8 texts (well-formed, broken and truncated) into the indexer
// with random gaps and stalls.
// Every byte taken is decoded by a local predictor, and each result entry is
// checked field by field, in order, against the oldest predicted entry.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_offset_indexer import uci_pkg::*; ();

   localparam logic [31:0] TEXT_LIMIT = DEFAULT_MAX_TEXT_BYTES;
   localparam logic [OFFSET_W-1:0] OFFSET_CAP =
      (TEXT_LIMIT > 32'd65535) ? 16'hFFFF : TEXT_LIMIT[OFFSET_W-1:0];
   localparam logic [VALUE_W-1:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam int unsigned RANDOM_ITEMS = 185;
   localparam int unsigned CALM_FROM    = 150;
   // Slowest run: ~220 bytes at up to 5 entries each, with random gaps and
   // stalls per entry, plus the long hold, then taken several times over.
   localparam longint unsigned CYCLE_LIMIT = 64'd20_000;

   typedef struct {
      logic [7:0] data;
      logic       eot;
      logic       calm;
   } text_item_type;

   typedef struct {
      entry_type ent;
      logic      last;
   } indexed_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   uci_req_if req_bus ();
   uci_rsp_if rsp_bus ();

   utf8_codepoint_offset_indexer #(
      .MAX_TEXT_BYTES (TEXT_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   text_item_type     byte_queue [$];
   indexed_entry_type due_entries [$];
   logic [7:0]        text_bytes [$];

   // decoder shadow state
   logic [7:0]          held_bytes [3];
   int unsigned         held_cnt = 0;
   int unsigned         seq_len  = 0;
   logic [OFFSET_W-1:0] byte_pos = '0;
   logic [OFFSET_W-1:0] unit_pos = '0;

   int unsigned err_cnt = 0;
   int unsigned bytes_sent = 0;
   int unsigned text_count = 0;
   int unsigned random_items = 0;
   int unsigned entries_checked = 0;
   int unsigned malformed_seen = 0;
   int unsigned sentinels_seen = 0;
   longint unsigned cycle_count = 0;

   logic          quiet_tail = 1'b0;
   int unsigned   gap_left = 0;
   int unsigned   hold_left = 0;
   logic          long_hold_done = 1'b0;
   text_item_type next_item;

   function automatic void append_byte(logic [7:0] v);
      text_bytes.insert(text_bytes.size(), v);
   endfunction

   function automatic logic [OFFSET_W-1:0] bump(logic [OFFSET_W-1:0] a, int unsigned d);
      int unsigned s;
      s = 32'(a) + d;
      return (s > 32'(OFFSET_CAP)) ? OFFSET_CAP : s[OFFSET_W-1:0];
   endfunction

   function automatic void push_entry(logic [VALUE_W-1:0] val, logic bad, logic sent);
      indexed_entry_type e;
      e.ent.byte_offset  = byte_pos;
      e.ent.unit_offset  = unit_pos;
      e.ent.scalar_value = val;
      e.ent.malformed    = bad;
      e.ent.is_sentinel  = sent;
      e.last             = 1'b0;
      due_entries.insert(due_entries.size(), e);
   endfunction

   // Push one decoded entry, then advance both offsets.
   function automatic void emit_scalar(logic [VALUE_W-1:0] val, logic bad, int unsigned nbytes);
      push_entry(val, bad, 1'b0);
      byte_pos = bump(byte_pos, nbytes);
      unit_pos = bump(unit_pos, (!bad && val >= SUPPLEMENTARY_BASE) ? 2 : 1);
   endfunction

   function automatic void flush_held();
      int unsigned k;
      for (k = 0; k < held_cnt; k++) emit_scalar('0, 1'b1, 1);
      held_cnt = 0;
      seq_len  = 0;
   endfunction

   function automatic void take_lead(logic [7:0] b, logic eot);
      int unsigned len;
      if (b < 8'h80) begin
         emit_scalar(VALUE_W'(b), 1'b0, 1);
         return;
      end
      if ((b & LEAD2_MASK) == LEAD2_CODE) len = 2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 4;
      else len = 0;
      if (len == 0 || eot) begin
         emit_scalar('0, 1'b1, 1);
      end else begin
         held_bytes[0] = b;
         held_cnt = 1;
         seq_len  = len;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] assemble_scalar(logic [7:0] b);
      case (seq_len)
         2: return VALUE_W'({held_bytes[0][4:0], b[5:0]});
         3: return VALUE_W'({held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]});
         default: return {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], b[5:0]};
      endcase
   endfunction

   // Predict every entry that one accepted byte causes.
   function automatic void decode_byte(logic [7:0] b, logic eot);
      int unsigned first;
      int unsigned len;
      logic [VALUE_W-1:0] val;
      first = due_entries.size();
      if (held_cnt != 0) begin
         if ((b & CONT_MASK) == CONT_CODE) begin
            if (held_cnt + 1 == seq_len) begin
               val = assemble_scalar(b);
               len = seq_len;
               held_cnt = 0;
               seq_len  = 0;
               emit_scalar(val, 1'b0, len);
            end else if (eot) begin
               flush_held();
               emit_scalar('0, 1'b1, 1);
            end else begin
               held_bytes[held_cnt] = b;
               held_cnt++;
            end
         end else begin
            flush_held();
            take_lead(b, eot);
         end
      end else begin
         take_lead(b, eot);
      end
      if (eot) begin
         push_entry('0, 1'b0, 1'b1);
         held_bytes = '{default: 8'h00};
         held_cnt = 0;
         seq_len  = 0;
         byte_pos = '0;
         unit_pos = '0;
      end
      if (due_entries.size() > first) due_entries[due_entries.size() - 1].last = 1'b1;
   endfunction

   // Append a lead for a len-byte sequence and ncont continuation bytes.
   function automatic void add_seq(int unsigned len, int unsigned ncont);
      logic [7:0] r;
      int unsigned k;
      r = 8'($urandom);
      case (len)
         1: append_byte({1'b0, r[6:0]});
         2: append_byte({3'b110, r[4:0]});
         3: append_byte({4'b1110, r[3:0]});
         default: append_byte({5'b11110, r[2:0]});
      endcase
      for (k = 0; k < ncont; k++) begin
         r = 8'($urandom);
         append_byte({2'b10, r[5:0]});
      end
   endfunction

   function automatic void end_text(logic calm);
      text_item_type it;
      int unsigned k;
      for (k = 0; k < text_bytes.size(); k++) begin
         it.data = text_bytes[k];
         it.eot  = (k == text_bytes.size() - 1);
         it.calm = calm;
         byte_queue.insert(byte_queue.size(), it);
      end
      text_bytes.delete();
      text_count++;
   endfunction

   function automatic void add_random_text(logic calm);
      int unsigned n_tok;
      int unsigned k;
      int unsigned len;
      int unsigned kind;
      logic [7:0] r;
      n_tok = $urandom_range(1, 10);
      for (k = 0; k < n_tok; k++) begin
         kind = $urandom_range(0, 9);
         r = 8'($urandom);
         case (kind)
            6: append_byte(r);
            7: append_byte({2'b10, r[5:0]});
            8: append_byte({5'b11111, r[2:0]});
            9: begin
               len = $urandom_range(2, 4);
               add_seq(len, $urandom_range(0, len - 2));
            end
            default: begin
               len = $urandom_range(1, 4);
               add_seq(len, len - 1);
            end
         endcase
      end
      // sometimes cut the text inside a multi-byte sequence
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(2, 4);
         add_seq(len, $urandom_range(0, len - 2));
      end
      random_items += text_bytes.size();
      end_text(calm);
   endfunction

   function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
      err_cnt++;
      if (err_cnt <= 40)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endfunction

   function automatic void check_entry();
      indexed_entry_type want;
      if (due_entries.size() == 0) begin
         err_cnt++;
         if (err_cnt <= 40)
            $display("%0t: unexpected entry, expected none, actual byte 0x%0h unit 0x%0h",
                     $time, rsp_bus.byte_offset, rsp_bus.unit_offset);
         return;
      end
      want = due_entries.pop_front();
      entries_checked++;
      if (rsp_bus.malformed === 1'b1) malformed_seen++;
      if (rsp_bus.is_sentinel === 1'b1) sentinels_seen++;
      if (rsp_bus.byte_offset !== want.ent.byte_offset)
         note_mismatch("byte_offset", 32'(want.ent.byte_offset), 32'(rsp_bus.byte_offset));
      if (rsp_bus.unit_offset !== want.ent.unit_offset)
         note_mismatch("unit_offset", 32'(want.ent.unit_offset), 32'(rsp_bus.unit_offset));
      if (rsp_bus.scalar_value !== want.ent.scalar_value)
         note_mismatch("scalar_value", 32'(want.ent.scalar_value),
                       32'(rsp_bus.scalar_value));
      if (rsp_bus.malformed !== want.ent.malformed)
         note_mismatch("malformed", 32'(want.ent.malformed), 32'(rsp_bus.malformed));
      if (rsp_bus.is_sentinel !== want.ent.is_sentinel)
         note_mismatch("is_sentinel", 32'(want.ent.is_sentinel), 32'(rsp_bus.is_sentinel));
      if (rsp_bus.last_of_run !== want.last)
         note_mismatch("last_of_run", 32'(want.last), 32'(rsp_bus.last_of_run));
   endfunction

   // Byte driver: hold an offered item until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            decode_byte(req_bus.data_byte, req_bus.end_of_text);
            bytes_sent++;
         end
         if (gap_left != 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (byte_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (!byte_queue[0].calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            req_bus.valid <= 1'b0;
         end else begin
            next_item = byte_queue.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.data_byte   <= next_item.data;
            req_bus.end_of_text <= next_item.eot;
            quiet_tail          <= next_item.calm;
         end
      end
   end

   // Entry monitor with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_entry();
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && entries_checked >= 100) begin
            long_hold_done = 1'b1;
            hold_left = 59;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("tb_utf8_codepoint_offset_indexer: done, errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      held_bytes = '{default: 8'h00};

      // ASCII extremes, each sequence length up to the largest 4-byte value,
      // stray continuation, bad lead, broken sequence, and a flush of three
      // held bytes plus a bad lead on the end byte
      text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hE2, 8'h41,
                     8'hF0, 8'h80, 8'h80, 8'hF8};
      end_text(1'b0);
      // end flag on a continuation inside a sequence
      text_bytes = '{8'hE2, 8'h82};
      end_text(1'b0);
      // multi-byte lead as the end byte
      text_bytes = '{8'hC3};
      end_text(1'b0);
      text_bytes = '{8'h41};
      end_text(1'b0);
      // end flag on the byte that completes a sequence
      text_bytes = '{8'hC2, 8'h80};
      end_text(1'b0);

      while (random_items < RANDOM_ITEMS) add_random_text(random_items >= CALM_FROM);

      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_bus.valid) @(posedge clock);
      while (due_entries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d bytes in %0d texts with gaps, stalls and one long hold-off",
               bytes_sent, text_count);
      $display("checked %0d entries: %0d malformed, %0d sentinels", entries_checked,
               malformed_seen, sentinels_seen);
      if (err_cnt == 0) begin
         $display("tb_utf8_codepoint_offset_indexer: done, clean");
      end else begin
         $display("tb_utf8_codepoint_offset_indexer: done, errors");
      end
      $finish;
   end

endmodule
